### design/dpr_pkg.sv
package dpr_pkg;

   localparam int MAX_PAYLOAD_DEFAULT  = 512;
   localparam int READ_CAP_DEFAULT     = 128;
   localparam int ADDRESS_BITS_DEFAULT = 64;

   localparam logic [7:0] CHAR_START  = 8'h24;
   localparam logic [7:0] CHAR_END    = 8'h23;
   localparam logic [7:0] CHAR_ACK    = 8'h2b;
   localparam logic [7:0] CHAR_NAK    = 8'h2d;
   localparam logic [7:0] CHAR_COMMA  = 8'h2c;
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_MEMORY = 8'h6d;
   localparam logic [7:0] CHAR_CONT   = 8'h63;
   localparam logic [7:0] CHAR_DETACH = 8'h44;
   localparam logic [7:0] CHAR_KILL   = 8'h6b;

   localparam logic [7:0] BAD_NIBBLE  = 8'hff;
   localparam logic [7:0] HEX_TEN     = 8'h0a;

   typedef enum logic [1:0] {
      TX_NONE = 2'd0,
      TX_ACK  = 2'd1,
      TX_NAK  = 2'd2
   } tx_code_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_PAYLOAD = 3'd1,
      PH_DIGIT1  = 3'd2,
      PH_DIGIT2  = 3'd3,
      PH_WAITACK = 3'd4,
      PH_ENDED   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [1:0]  tx_code;
      logic        resend_request;
      logic        packet_ok;
      logic [7:0]  command_letter;
      logic [8:0]  payload_length;
      logic [63:0] read_address;
      logic [7:0]  read_length;
      logic        session_end;
   } result_type;

   function automatic logic [7:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      if (b >= 8'h30 && b <= 8'h39) begin
         v = b - 8'h30;
      end else if (b >= 8'h41 && b <= 8'h46) begin
         v = HEX_TEN + (b - 8'h41);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         v = HEX_TEN + (b - 8'h61);
      end else begin
         v = BAD_NIBBLE;
      end
      return v;
   endfunction

endpackage

### design/dpr_channels.sv
interface dpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface dpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  tx_code;
   logic        resend_request;
   logic        packet_ok;
   logic [7:0]  command_letter;
   logic [8:0]  payload_length;
   logic [63:0] read_address;
   logic [7:0]  read_length;
   logic        session_end;

   modport source (output valid, output tx_code, output resend_request, output packet_ok,
                   output command_letter, output payload_length, output read_address,
                   output read_length, output session_end, input ready);
   modport sink (input valid, input tx_code, input resend_request, input packet_ok,
                 input command_letter, input payload_length, input read_address,
                 input read_length, input session_end, output ready);
endinterface

### design/dpr_core.sv
module dpr_core #(
   parameter int MAX_PAYLOAD  = dpr_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int READ_CAP     = dpr_pkg::READ_CAP_DEFAULT,
   parameter int ADDRESS_BITS = dpr_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic [7:0]           rx_byte,
   output dpr_pkg::result_type  result
);

   localparam int CNT_W = $clog2(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PAYLOAD - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [63:0] CAP = 64'(READ_CAP);

   dpr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]              running_sum_ff, running_sum_in;
   logic [11:0]             received_sum_ff, received_sum_in;
   logic [CNT_W-1:0]        byte_count_ff, byte_count_in;
   logic [CNT_W-1:0]        text_length_ff, text_length_in;
   logic [7:0]              first_byte_ff, first_byte_in;
   logic                    string_ended_ff, string_ended_in;
   logic                    past_comma_ff, past_comma_in;
   logic [ADDRESS_BITS-1:0] address_accum_ff, address_accum_in;
   logic [63:0]             length_accum_ff, length_accum_in;
   logic                    overflowed_ff, overflowed_in;

   logic [7:0]  nibble;
   logic [12:0] got_sum;
   logic        sum_good;
   logic        ends_session;

   assign nibble       = dpr_pkg::hex_value(rx_byte);
   assign got_sum      = {1'b0, received_sum_ff} + {5'd0, nibble};
   assign sum_good     = !overflowed_ff && (got_sum == {5'd0, running_sum_ff});
   assign ends_session = (first_byte_ff == dpr_pkg::CHAR_CONT)
                      || (first_byte_ff == dpr_pkg::CHAR_DETACH)
                      || (first_byte_ff == dpr_pkg::CHAR_KILL);

   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         dpr_pkg::PH_HUNT: begin
            if (rx_byte == dpr_pkg::CHAR_START) phase_in = dpr_pkg::PH_PAYLOAD;
         end
         dpr_pkg::PH_PAYLOAD: begin
            if (rx_byte == dpr_pkg::CHAR_END) phase_in = dpr_pkg::PH_DIGIT1;
         end
         dpr_pkg::PH_DIGIT1: phase_in = dpr_pkg::PH_DIGIT2;
         dpr_pkg::PH_DIGIT2: begin
            if (!sum_good) phase_in = dpr_pkg::PH_HUNT;
            else if (ends_session) phase_in = dpr_pkg::PH_ENDED;
            else phase_in = dpr_pkg::PH_WAITACK;
         end
         dpr_pkg::PH_WAITACK: begin
            if (rx_byte != dpr_pkg::CHAR_NAK) phase_in = dpr_pkg::PH_HUNT;
         end
         default: phase_in = dpr_pkg::PH_ENDED;
      endcase
   end

   always_comb begin
      running_sum_in   = running_sum_ff;
      received_sum_in  = received_sum_ff;
      byte_count_in    = byte_count_ff;
      text_length_in   = text_length_ff;
      first_byte_in    = first_byte_ff;
      string_ended_in  = string_ended_ff;
      past_comma_in    = past_comma_ff;
      address_accum_in = address_accum_ff;
      length_accum_in  = length_accum_ff;
      overflowed_in    = overflowed_ff;
      result           = '0;
      case (phase_ff)
         dpr_pkg::PH_HUNT: begin
            if (rx_byte == dpr_pkg::CHAR_START) begin
               running_sum_in   = '0;
               received_sum_in  = '0;
               byte_count_in    = '0;
               text_length_in   = '0;
               first_byte_in    = '0;
               string_ended_in  = 1'b0;
               past_comma_in    = 1'b0;
               address_accum_in = '0;
               length_accum_in  = '0;
               overflowed_in    = 1'b0;
            end
         end
         dpr_pkg::PH_PAYLOAD: begin
            if (rx_byte != dpr_pkg::CHAR_END) begin
               if (byte_count_ff >= CNT_LAST) begin
                  overflowed_in = 1'b1;
               end else begin
                  if (byte_count_ff == '0) first_byte_in = rx_byte;
                  if (!string_ended_ff) begin
                     if (rx_byte == dpr_pkg::CHAR_NUL) begin
                        string_ended_in = 1'b1;
                     end else begin
                        running_sum_in = running_sum_ff + rx_byte;
                        text_length_in = text_length_ff + CNT_ONE;
                        if (byte_count_ff != '0) begin
                           if (!past_comma_ff && rx_byte == dpr_pkg::CHAR_COMMA) begin
                              past_comma_in = 1'b1;
                           end else if (!past_comma_ff) begin
                              address_accum_in = (address_accum_ff << 4)
                                               + ADDRESS_BITS'(nibble);
                           end else begin
                              length_accum_in = (length_accum_ff << 4) + 64'(nibble);
                           end
                        end
                     end
                  end
                  byte_count_in = byte_count_ff + CNT_ONE;
               end
            end
         end
         dpr_pkg::PH_DIGIT1: begin
            received_sum_in = {nibble, 4'd0};
         end
         dpr_pkg::PH_DIGIT2: begin
            if (!sum_good) begin
               result.tx_code = dpr_pkg::TX_NAK;
            end else begin
               result.tx_code        = dpr_pkg::TX_ACK;
               result.packet_ok      = 1'b1;
               result.command_letter = first_byte_ff;
               result.payload_length = 9'(text_length_ff);
               result.session_end    = ends_session;
               if (first_byte_ff == dpr_pkg::CHAR_MEMORY) begin
                  result.read_address = 64'(address_accum_ff);
                  result.read_length  = (length_accum_ff > CAP) ? 8'(CAP)
                                                                : 8'(length_accum_ff);
               end
            end
         end
         dpr_pkg::PH_WAITACK: begin
            if (rx_byte == dpr_pkg::CHAR_NAK) begin
               result.resend_request = 1'b1;
            end else if (rx_byte != dpr_pkg::CHAR_ACK) begin
               result.tx_code = dpr_pkg::TX_NAK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= dpr_pkg::PH_HUNT;
         running_sum_ff   <= '0;
         received_sum_ff  <= '0;
         byte_count_ff    <= '0;
         text_length_ff   <= '0;
         first_byte_ff    <= '0;
         string_ended_ff  <= 1'b0;
         past_comma_ff    <= 1'b0;
         address_accum_ff <= '0;
         length_accum_ff  <= '0;
         overflowed_ff    <= 1'b0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         running_sum_ff   <= running_sum_in;
         received_sum_ff  <= received_sum_in;
         byte_count_ff    <= byte_count_in;
         text_length_ff   <= text_length_in;
         first_byte_ff    <= first_byte_in;
         string_ended_ff  <= string_ended_in;
         past_comma_ff    <= past_comma_in;
         address_accum_ff <= address_accum_in;
         length_accum_ff  <= length_accum_in;
         overflowed_ff    <= overflowed_in;
      end
   end

endmodule

### design/debug_packet_receiver_unit.sv
// Channel   Direction  Payload
// req_bus   in         rx_byte
// rsp_bus   out        tx_code, resend_request, packet_ok, command_letter,
//                      payload_length, read_address, read_length, session_end
//
// Every byte yields exactly one result transaction once it has passed through the
// input register and the result register. One byte per cycle is sustained while
// results are taken; the packet state updates between those registers.
// Reset is synchronous and returns the receiver to hunting for a start byte.
// A stalled result holds the pipeline; the input register still takes a byte
// whenever it is empty.
module debug_packet_receiver_unit #(
   parameter int MAX_PAYLOAD  = dpr_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int READ_CAP     = dpr_pkg::READ_CAP_DEFAULT,
   parameter int ADDRESS_BITS = dpr_pkg::ADDRESS_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   dpr_req_if.sink   req_bus,
   dpr_rsp_if.source rsp_bus
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff, out_valid_in;
   dpr_pkg::result_type out_data_ff;
   dpr_pkg::result_type result;
   logic                advance;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign in_valid_in   = req_bus.valid || (in_valid_ff && !advance);
   assign out_valid_in  = advance || (out_valid_ff && !rsp_bus.ready);

   dpr_core #(
      .MAX_PAYLOAD  (MAX_PAYLOAD),
      .READ_CAP     (READ_CAP),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) in_byte_ff <= req_bus.rx_byte;
      if (advance) out_data_ff <= result;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.tx_code        = out_data_ff.tx_code;
   assign rsp_bus.resend_request = out_data_ff.resend_request;
   assign rsp_bus.packet_ok      = out_data_ff.packet_ok;
   assign rsp_bus.command_letter = out_data_ff.command_letter;
   assign rsp_bus.payload_length = out_data_ff.payload_length;
   assign rsp_bus.read_address   = out_data_ff.read_address;
   assign rsp_bus.read_length    = out_data_ff.read_length;
   assign rsp_bus.session_end    = out_data_ff.session_end;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import dpr_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int CALM_FROM    = 700;
   localparam int CALM_TO      = 1000;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 20;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BAD_DIGIT,
      FRAME_CUT
   } frame_mode_type;

   class packet_scoreboard;
      phase_type   phase;
      logic [7:0]  run_sum;
      logic [11:0] sum_high;
      int unsigned stored;
      int unsigned text_len;
      logic [7:0]  letter;
      bit          nul_seen;
      bit          comma_seen;
      bit          too_long;
      logic [63:0] addr_acc;
      logic [63:0] len_acc;
      result_type  expected_q[$];
      int          errors;

      function new();
         phase  = PH_HUNT;
         errors = 0;
         restart_packet();
      endfunction

      static function logic [7:0] nibble_of(logic [7:0] b);
         if (b >= "0" && b <= "9") begin
            return b - "0";
         end else if (b >= "A" && b <= "F") begin
            return HEX_TEN + (b - "A");
         end else if (b >= "a" && b <= "f") begin
            return HEX_TEN + (b - "a");
         end
         return BAD_NIBBLE;
      endfunction

      function void restart_packet();
         run_sum    = '0;
         sum_high   = '0;
         stored     = 0;
         text_len   = 0;
         letter     = '0;
         nul_seen   = 1'b0;
         comma_seen = 1'b0;
         too_long   = 1'b0;
         addr_acc   = '0;
         len_acc    = '0;
      endfunction

      function void absorb(logic [7:0] b);
         if (stored >= MAX_PAYLOAD_DEFAULT - 1) begin
            too_long = 1'b1;
            return;
         end
         if (stored == 0) begin
            letter = b;
         end
         if (!nul_seen) begin
            if (b == CHAR_NUL) begin
               nul_seen = 1'b1;
            end else begin
               run_sum  = run_sum + b;
               text_len = text_len + 1;
               if (stored >= 1) begin
                  if (!comma_seen && b == CHAR_COMMA) begin
                     comma_seen = 1'b1;
                  end else if (!comma_seen) begin
                     addr_acc = (addr_acc << 4) + {56'd0, nibble_of(b)};
                  end else begin
                     len_acc = (len_acc << 4) + {56'd0, nibble_of(b)};
                  end
               end
            end
         end
         stored = stored + 1;
      endfunction

      function void note_byte(logic [7:0] b);
         result_type  r;
         int unsigned got;
         r = '0;
         case (phase)
            PH_HUNT: begin
               if (b == CHAR_START) begin
                  restart_packet();
                  phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               if (b == CHAR_END) begin
                  phase = PH_DIGIT1;
               end else begin
                  absorb(b);
               end
            end
            PH_DIGIT1: begin
               sum_high = {nibble_of(b), 4'h0};
               phase    = PH_DIGIT2;
            end
            PH_DIGIT2: begin
               got = 32'(sum_high) + 32'(nibble_of(b));
               if (too_long || got != 32'(run_sum)) begin
                  r.tx_code = TX_NAK;
                  phase     = PH_HUNT;
               end else begin
                  r.tx_code        = TX_ACK;
                  r.packet_ok      = 1'b1;
                  r.command_letter = letter;
                  r.payload_length = text_len[8:0];
                  if (letter == CHAR_MEMORY) begin
                     r.read_address = addr_acc;
                     r.read_length  = (len_acc > 64'(READ_CAP_DEFAULT)) ?
                                      8'(READ_CAP_DEFAULT) : len_acc[7:0];
                  end
                  if (letter == CHAR_CONT || letter == CHAR_DETACH || letter == CHAR_KILL) begin
                     r.session_end = 1'b1;
                     phase         = PH_ENDED;
                  end else begin
                     phase = PH_WAITACK;
                  end
               end
            end
            PH_WAITACK: begin
               if (b == CHAR_ACK) begin
                  phase = PH_HUNT;
               end else if (b == CHAR_NAK) begin
                  r.resend_request = 1'b1;
               end else begin
                  r.tx_code = TX_NAK;
                  phase     = PH_HUNT;
               end
            end
            default: begin
               phase = PH_ENDED;
            end
         endcase
         expected_q.push_back(r);
      endfunction

      function void compare_field(string label, logic [63:0] want, logic [63:0] seen);
         if (want !== seen) begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, label, want, seen);
         end
      endfunction

      function void check_result(result_type seen);
         result_type want;
         if (expected_q.size() == 0) begin
            errors = errors + 1;
            $display("%0t: unexpected result, expected none, actual 0x%0h", $time, seen);
            return;
         end
         want = expected_q.pop_front();
         compare_field("tx_code", 64'(want.tx_code), 64'(seen.tx_code));
         compare_field("resend_request", 64'(want.resend_request), 64'(seen.resend_request));
         compare_field("packet_ok", 64'(want.packet_ok), 64'(seen.packet_ok));
         compare_field("command_letter", 64'(want.command_letter), 64'(seen.command_letter));
         compare_field("payload_length", 64'(want.payload_length), 64'(seen.payload_length));
         compare_field("read_address", want.read_address, seen.read_address);
         compare_field("read_length", 64'(want.read_length), 64'(seen.read_length));
         compare_field("session_end", 64'(want.session_end), 64'(seen.session_end));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic sink_ready = 1'b0;
   bit   calm = 1'b0;
   int   sent_count = 0;
   int   cycles = 0;

   logic [7:0] body_q[$];
   logic [7:0] cmd_table [0:7] = '{"g", "G", "M", "q", "s", "H", "p", "?"};

   packet_scoreboard sb;

   dpr_req_if req_bus ();
   dpr_rsp_if rsp_bus ();

   assign rsp_bus.ready = sink_ready;

   debug_packet_receiver_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      sink_ready <= calm || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin : monitor
      result_type seen;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            sb.note_byte(req_bus.rx_byte);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.tx_code        = rsp_bus.tx_code;
            seen.resend_request = rsp_bus.resend_request;
            seen.packet_ok      = rsp_bus.packet_ok;
            seen.command_letter = rsp_bus.command_letter;
            seen.payload_length = rsp_bus.payload_length;
            seen.read_address   = rsp_bus.read_address;
            seen.read_length    = rsp_bus.read_length;
            seen.session_end    = rsp_bus.session_end;
            sb.check_result(seen);
         end
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      calm = (sent_count >= CALM_FROM && sent_count < CALM_TO);
      while (!calm && $urandom_range(99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      sent_count = sent_count + 1;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n);
      logic [7:0] base;
      if (n < 4'd10) begin
         return "0" + {4'd0, n};
      end
      base = $urandom_range(1) ? "A" : "a";
      return base + {4'd0, n - 4'd10};
   endfunction

   function automatic logic [7:0] bad_char();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (packet_scoreboard::nibble_of(b) != BAD_NIBBLE || b == CHAR_END ||
                 b == CHAR_COMMA);
      return b;
   endfunction

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == CHAR_END);
      return b;
   endfunction

   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == CHAR_START);
      return b;
   endfunction

   function automatic logic [7:0] digit_or_bad();
      int r;
      r = $urandom_range(39);
      if (r == 0) begin
         return bad_char();
      end else if (r == 1) begin
         return CHAR_COMMA;
      end
      return hex_char(4'($urandom_range(15)));
   endfunction

   function automatic logic [7:0] body_sum();
      logic [7:0] s;
      s = '0;
      for (int i = 0; i < body_q.size(); i++) begin
         if (body_q[i] == CHAR_NUL) begin
            break;
         end
         s = s + body_q[i];
      end
      return s;
   endfunction

   task automatic build_memory_read();
      int na;
      int nl;
      body_q.delete();
      body_q.push_back(CHAR_MEMORY);
      na = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 12);
      for (int i = 0; i < na; i++) begin
         body_q.push_back(digit_or_bad());
      end
      if ($urandom_range(9) != 0) begin
         body_q.push_back(CHAR_COMMA);
         nl = ($urandom_range(7) == 0) ? $urandom_range(4, 17) : $urandom_range(1, 2);
         for (int i = 0; i < nl; i++) begin
            body_q.push_back(digit_or_bad());
         end
      end
      if ($urandom_range(9) == 0) begin
         body_q.push_back(CHAR_NUL);
         repeat ($urandom_range(0, 3)) body_q.push_back(body_byte());
      end
   endtask

   task automatic build_other(input int n);
      logic [7:0] first;
      body_q.delete();
      if ($urandom_range(1)) begin
         first = cmd_table[3'($urandom_range(7))];
      end else begin
         do begin
            first = body_byte();
         end while (first == CHAR_CONT || first == CHAR_DETACH || first == CHAR_KILL);
      end
      body_q.push_back(first);
      for (int i = 1; i < n; i++) begin
         body_q.push_back(body_byte());
      end
   endtask

   task automatic send_frame(input frame_mode_type mode);
      logic [7:0] sum;
      logic [7:0] hi;
      logic [7:0] lo;
      sum = body_sum();
      if (mode == FRAME_BAD_SUM) begin
         sum = sum ^ 8'($urandom_range(1, 255));
      end
      send_byte(CHAR_START);
      for (int i = 0; i < body_q.size(); i++) begin
         send_byte(body_q[i]);
      end
      if (mode == FRAME_CUT) begin
         return;
      end
      send_byte(CHAR_END);
      hi = hex_char(sum[7:4]);
      lo = hex_char(sum[3:0]);
      if (mode == FRAME_BAD_DIGIT) begin
         if ($urandom_range(1)) begin
            hi = bad_char();
         end else begin
            lo = bad_char();
         end
      end
      send_byte(hi);
      send_byte(lo);
   endtask

   task automatic answer_reply();
      int r;
      logic [7:0] b;
      r = $urandom_range(99);
      if (r < 60) begin
         send_byte(CHAR_ACK);
      end else if (r < 75) begin
         repeat ($urandom_range(1, 3)) send_byte(CHAR_NAK);
         send_byte(CHAR_ACK);
      end else if (r < 87) begin
         do begin
            b = 8'($urandom_range(255));
         end while (b == CHAR_ACK || b == CHAR_NAK);
         send_byte(b);
      end
   endtask

   task automatic return_to_hunt();
      wait_for_results();
      while (sb.phase != PH_HUNT && sb.phase != PH_ENDED) begin
         case (sb.phase)
            PH_PAYLOAD: send_byte(CHAR_END);
            PH_WAITACK: send_byte(CHAR_ACK);
            default: send_byte("0");
         endcase
         wait_for_results();
      end
   endtask

   initial begin
      int             packets;
      int             r;
      int             stop_at;
      frame_mode_type mode;
      sb = new();
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Junk at both ends of the byte range is dropped while hunting.
      send_byte(8'h00);
      send_byte(8'hff);
      // Memory read with a bad address digit, a second comma, and bytes after a NUL.
      body_q = '{CHAR_MEMORY, "1", "z", CHAR_COMMA, "8", CHAR_COMMA, CHAR_NUL, 8'hff};
      send_frame(FRAME_GOOD);
      send_byte(CHAR_NAK);
      send_byte(CHAR_ACK);
      // An empty packet, then a stray byte while the ack is awaited.
      body_q.delete();
      send_frame(FRAME_GOOD);
      send_byte("x");
      body_q = '{"g"};
      send_frame(FRAME_BAD_DIGIT);

      wait_for_results();

      packets = 0;
      stop_at = sent_count + RANDOM_ITEMS;
      while (sent_count < stop_at) begin
         if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(junk_byte());
         end
         r = $urandom_range(99);
         if (packets == 20) begin
            build_other(MAX_PAYLOAD_DEFAULT - 1);
         end else if (packets == 40) begin
            build_other(MAX_PAYLOAD_DEFAULT + $urandom_range(0, 8));
         end else if (r < 50) begin
            build_memory_read();
         end else if (r < 92) begin
            build_other($urandom_range(1, 12));
         end else begin
            body_q.delete();
         end
         r = $urandom_range(99);
         if (packets == 20 || packets == 40 || r < 76) begin
            mode = FRAME_GOOD;
         end else if (r < 86) begin
            mode = FRAME_BAD_SUM;
         end else if (r < 94) begin
            mode = FRAME_BAD_DIGIT;
         end else begin
            mode = FRAME_CUT;
         end
         send_frame(mode);
         if (mode == FRAME_GOOD) begin
            answer_reply();
         end
         if (packets == 60) begin
            wait_for_results();
         end
         packets = packets + 1;
      end

      // Close the session for good; everything after it is ignored.
      return_to_hunt();
      case ($urandom_range(2))
         0: body_q = '{CHAR_CONT};
         1: body_q = '{CHAR_DETACH};
         default: body_q = '{CHAR_KILL};
      endcase
      repeat ($urandom_range(0, 3)) body_q.push_back(body_byte());
      send_frame(FRAME_GOOD);
      body_q = '{CHAR_MEMORY};
      send_frame(FRAME_GOOD);
      send_byte(CHAR_ACK);

      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
design/dpr_pkg.sv
design/dpr_channels.sv
design/dpr_core.sv
design/debug_packet_receiver_unit.sv
tb/tb_top.sv
